[src/assert_macros.svh]
// Concurrent assertion helpers used by drrip_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, disabled while reset is active.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ON(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/drrip_pkg.sv]
package drrip_pkg;

  // Default geometry.
  localparam int unsigned NumSetsDef    = 2048;
  localparam int unsigned NumWaysDef    = 16;
  localparam int unsigned LeaderSetsDef = 32;
  localparam int unsigned DuelBitsDef   = 10;

  // Fixed field widths of the channels.
  localparam int unsigned SetInW   = 11;
  localparam int unsigned WayInW   = 4;
  localparam int unsigned ChanceW  = 5;
  localparam int unsigned VictimW  = 4;
  localparam int unsigned RvW      = 2;
  localparam int unsigned DuelOutW = 10;

  // Widest set and way index over the supported geometry range.
  localparam int unsigned SetMaxW = 16;
  localparam int unsigned WayMaxW = 5;

  localparam int unsigned QueueDepth = 2;

  localparam logic [RvW-1:0] RvMax    = 2'd3;
  localparam logic [RvW-1:0] RvNear   = 2'd1;
  localparam logic [RvW-1:0] RvHit    = 2'd0;

  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ROLE_FOLLOW,
    ROLE_SRRIP,
    ROLE_BRRIP
  } drrip_role_e;

  typedef struct packed {
    logic               command;
    logic [SetInW-1:0]  set_index;
    logic [WayInW-1:0]  way_index;
    logic               is_hit;
    logic               victim_valid;
    logic [ChanceW-1:0] chance;
  } drrip_in_t;

  typedef struct packed {
    logic [VictimW-1:0]  victim_way;
    logic [RvW-1:0]      inserted_value;
    logic [DuelOutW-1:0] duel_counter;
  } drrip_out_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic               update;
    logic               is_hit;
    logic               victim_valid;
    logic               chance_zero;
    drrip_role_e        role;
    logic [SetMaxW-1:0] set;
    logic [WayMaxW-1:0] way;
  } drrip_op_t;

endpackage

[src/drrip_cache_replacement.sv]
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | in_data_i  (drrip_in_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (drrip_out_t)
//
// In the back end each item goes through row read, victim/update compute and row write back.
// The back end takes a new item only after writing back the last one's set row.
// After reset the set memory is filled with the max value, one row per cycle, all NUM_SETS
// rows (2048 by default), with in_ready_o low.
// A 2-entry queue parts the front end from the back end; the output register holds a result
// while the next item is already being accepted.
module drrip_cache_replacement
  import drrip_pkg::*;
#(
  parameter int unsigned NUM_SETS    = NumSetsDef,
  parameter int unsigned NUM_WAYS    = NumWaysDef,
  parameter int unsigned LEADER_SETS = LeaderSetsDef,
  parameter int unsigned DUEL_BITS   = DuelBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  drrip_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output drrip_out_t out_data_o
);

  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  logic      clear_done;
  drrip_op_t op_in;
  drrip_op_t op_head;

  drrip_front #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .LEADER_SETS (LEADER_SETS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .q_full_i     (q_full),
    .clear_done_i (clear_done),
    .push_o       (push),
    .op_o         (op_in)
  );

  drrip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .pop_i   (pop),
    .data_o  (op_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  drrip_back #(
    .NUM_SETS  (NUM_SETS),
    .NUM_WAYS  (NUM_WAYS),
    .DUEL_BITS (DUEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (op_head),
    .pop_o        (pop),
    .clear_done_o (clear_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

[src/drrip_front.sv]
module drrip_front
  import drrip_pkg::*;
#(
  parameter int unsigned NUM_SETS    = NumSetsDef,
  parameter int unsigned NUM_WAYS    = NumWaysDef,
  parameter int unsigned LEADER_SETS = LeaderSetsDef
) (
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  drrip_in_t in_data_i,
  input  logic      q_full_i,
  input  logic      clear_done_i,
  output logic      push_o,
  output drrip_op_t op_o
);

  localparam int unsigned SetW = $clog2(NUM_SETS);
  localparam int unsigned WayW = $clog2(NUM_WAYS);
  localparam int unsigned SetModSteps =
    (NUM_SETS >= (1 << SetInW)) ? 0 : SetInW - $clog2(NUM_SETS) + 1;
  localparam int unsigned WayModSteps =
    (NUM_WAYS >= (1 << WayInW)) ? 0 : WayInW - $clog2(NUM_WAYS) + 1;

  logic [SetInW-1:0] set_rem;
  logic [WayInW-1:0] way_rem;
  logic [SetW-1:0]   set_red;
  logic [WayW-1:0]   way_red;
  drrip_role_e       role;

  // Reduce set and way into range by restoring subtraction of shifted sizes.
  always_comb begin
    set_rem = in_data_i.set_index;
    for (int k = int'(SetModSteps) - 1; k >= 0; k--) begin
      if (32'(set_rem) >= (NUM_SETS << k)) begin
        set_rem = set_rem - SetInW'(NUM_SETS << k);
      end
    end
    way_rem = in_data_i.way_index;
    for (int k = int'(WayModSteps) - 1; k >= 0; k--) begin
      if (32'(way_rem) >= (NUM_WAYS << k)) begin
        way_rem = way_rem - WayInW'(NUM_WAYS << k);
      end
    end
  end

  assign set_red = SetW'(set_rem);
  assign way_red = WayW'(way_rem);

  // Sets in both leader groups count as BRRIP leaders.
  always_comb begin
    if (32'(set_red) + LEADER_SETS >= NUM_SETS) begin
      role = ROLE_BRRIP;
    end else if (32'(set_red) < LEADER_SETS) begin
      role = ROLE_SRRIP;
    end else begin
      role = ROLE_FOLLOW;
    end
  end

  assign in_ready_o = clear_done_i && !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    op_o.update       = (in_data_i.command == CMD_UPDATE);
    op_o.is_hit       = in_data_i.is_hit;
    op_o.victim_valid = in_data_i.victim_valid;
    op_o.chance_zero  = (in_data_i.chance == '0);
    op_o.role         = role;
    op_o.set          = SetMaxW'(set_red);
    op_o.way          = WayMaxW'(way_red);
  end

endmodule

[src/drrip_queue.sv]
module drrip_queue
  import drrip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  drrip_op_t data_i,
  input  logic      pop_i,
  output drrip_op_t data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  drrip_op_t       entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/drrip_back.sv]
`include "assert_macros.svh"

module drrip_back
  import drrip_pkg::*;
#(
  parameter int unsigned NUM_SETS  = NumSetsDef,
  parameter int unsigned NUM_WAYS  = NumWaysDef,
  parameter int unsigned DUEL_BITS = DuelBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  drrip_op_t  q_head_i,
  output logic       pop_o,
  output logic       clear_done_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output drrip_out_t out_data_o
);

  localparam int unsigned SetW = $clog2(NUM_SETS);
  localparam int unsigned WayW = $clog2(NUM_WAYS);
  localparam int unsigned RowW = NUM_WAYS * RvW;

  localparam logic [DUEL_BITS-1:0] DuelMax  = '1;
  localparam logic [DUEL_BITS-1:0] DuelHalf = DuelMax >> 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [SetW-1:0]      clr_q, clr_d;
  logic [DUEL_BITS-1:0] duel_q, duel_d;
  logic                 out_valid_q, out_valid_d;
  drrip_op_t            op_q;
  logic [RowW-1:0]      rdata_q;
  logic [RowW-1:0]      row_new_q, row_new_d;
  drrip_out_t           stage_q, stage_d;
  drrip_out_t           out_q;
  logic [RowW-1:0]      mem_q [NUM_SETS];

  logic                 out_free;
  logic                 load_out;
  logic                 wr_en;
  logic [SetW-1:0]      wr_addr;
  logic [RowW-1:0]      wr_data;
  logic [SetW-1:0]      op_set;
  logic [WayW-1:0]      op_way;

  logic [RvW-1:0]       rv   [NUM_WAYS];
  logic [RvW-1:0]       aged [NUM_WAYS];
  logic                 any3, any2, any1;
  logic [RvW-1:0]       top, add;
  logic [WayW-1:0]      victim;
  logic                 found;
  logic                 brrip;
  logic [RvW-1:0]       ins;
  logic [RowW-1:0]      aged_row, upd_row;

  assign op_set = op_q.set[SetW-1:0];
  assign op_way = op_q.way[WayW-1:0];

  // Victim search: age the whole set in one add so the oldest block reaches the max.
  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < int'(NUM_WAYS); w++) begin
      rv[w] = rdata_q[w*RvW +: RvW];
      any3  = any3 | (rv[w] == 2'd3);
      any2  = any2 | (rv[w] == 2'd2);
      any1  = any1 | (rv[w] == 2'd1);
    end
    top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
    add = RvMax - top;
    found  = 1'b0;
    victim = '0;
    for (int w = 0; w < int'(NUM_WAYS); w++) begin
      aged[w] = rv[w] + add;
      aged_row[w*RvW +: RvW] = aged[w];
      if (!found && aged[w] == RvMax) begin
        victim = WayW'(w);
        found  = 1'b1;
      end
    end
  end

  // Update: insertion value and training of the duel counter.
  always_comb begin
    unique case (op_q.role)
      ROLE_SRRIP: brrip = 1'b0;
      ROLE_BRRIP: brrip = 1'b1;
      default:    brrip = (duel_q >= DuelHalf);
    endcase
    if (op_q.is_hit) begin
      ins = RvHit;
    end else if (brrip && !op_q.chance_zero) begin
      ins = RvMax;
    end else begin
      ins = RvNear;
    end
    for (int w = 0; w < int'(NUM_WAYS); w++) begin
      upd_row[w*RvW +: RvW] = (WayW'(w) == op_way) ? ins : rv[w];
    end
    duel_d = duel_q;
    if (op_q.update && !op_q.is_hit && op_q.victim_valid) begin
      if (op_q.role == ROLE_SRRIP && duel_q != DuelMax) begin
        duel_d = duel_q + 1'b1;
      end else if (op_q.role == ROLE_BRRIP && duel_q != '0) begin
        duel_d = duel_q - 1'b1;
      end
    end
  end

  always_comb begin
    row_new_d               = op_q.update ? upd_row : aged_row;
    stage_d.victim_way      = op_q.update ? '0 : VictimW'(victim);
    stage_d.inserted_value  = op_q.update ? ins : '0;
    stage_d.duel_counter    = DuelOutW'(duel_d);
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == SetW'(NUM_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        // Hold the row until the output register can take the result.
        if (out_free) begin
          wr_en    = 1'b1;
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign wr_addr = (state_q == ST_CLEAR) ? clr_q : op_set;
  assign wr_data = (state_q == ST_CLEAR) ? '1 : row_new_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      duel_q      <= DuelHalf;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_READ) begin
        duel_q <= duel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q <= q_head_i;
    end
    if (state_q == ST_READ) begin
      row_new_q <= row_new_d;
      stage_q   <= stage_d;
    end
    if (load_out) begin
      out_q <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (pop_o) begin
      rdata_q <= mem_q[q_head_i.set[SetW-1:0]];
    end
  end

  assign clear_done_o = (state_q != ST_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  `ASSERT_ON(a_pop_only_idle, clk_i, pop_o |-> state_q == ST_IDLE, "pop outside idle")
  `ASSERT_RST(a_duel_only_read, clk_i, rst_ni, (state_q != ST_READ) |=> $stable(duel_q), "duel counter moved outside compute")
  `ASSERT_RST(a_out_from_write, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ST_WRITE, "result raised without write back")

endmodule

[verif/drrip_cache_replacement_tb.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import drrip_pkg::*;

  localparam int unsigned NumRows     = NumSetsDef * NumWaysDef;
  localparam logic [DuelBitsDef-1:0] DuelTop  = '1;
  localparam logic [DuelBitsDef-1:0] DuelHalf = DuelTop >> 1;
  localparam int unsigned StallLimit  = 10000;
  localparam int unsigned ReportLimit = 10;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  drrip_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  drrip_out_t out_data_o;

  drrip_cache_replacement i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mirror of the replacement state.
  logic [RvW-1:0]         rrpv_mem [NumRows];
  logic [DuelBitsDef-1:0] duel_cnt;
  drrip_out_t             expected_q [$];

  int unsigned idle_odds  = 0;
  int unsigned ready_hold = 0;
  int unsigned stall_cnt  = 0;
  int unsigned errors     = 0;
  int unsigned sent       = 0;
  int unsigned n_victim   = 0;
  int unsigned n_hit      = 0;
  int unsigned n_fill     = 0;
  int unsigned ageing_seen [4] = '{0, 0, 0, 0};
  bit          duel_saw_top   = 1'b0;
  bit          duel_saw_floor = 1'b0;

  function automatic drrip_role_e set_role(input logic [SetInW-1:0] idx);
    if (int'(idx) + LeaderSetsDef >= NumSetsDef) return ROLE_BRRIP;
    if (idx < LeaderSetsDef) return ROLE_SRRIP;
    return ROLE_FOLLOW;
  endfunction

  // Apply one access to the mirrored state and return the result it produces.
  function automatic drrip_out_t rrip_access(input drrip_in_t req);
    drrip_out_t     res;
    int unsigned    base;
    int             w;
    logic [RvW-1:0] top;
    logic [RvW-1:0] step;
    logic [RvW-1:0] ins;
    drrip_role_e    role;
    bit             brrip;
    res  = '0;
    base = req.set_index * NumWaysDef;
    if (req.command == CMD_VICTIM) begin
      n_victim++;
      top = RvHit;
      for (w = 0; w < NumWaysDef; w++) begin
        if (rrpv_mem[base+w] > top) top = rrpv_mem[base+w];
      end
      step = RvMax - top;
      ageing_seen[step]++;
      for (w = 0; w < NumWaysDef; w++) rrpv_mem[base+w] += step;
      // Scan downward so the lowest distant way wins.
      for (w = NumWaysDef - 1; w >= 0; w--) begin
        if (rrpv_mem[base+w] == RvMax) res.victim_way = w[VictimW-1:0];
      end
    end else if (req.is_hit) begin
      n_hit++;
      rrpv_mem[base+req.way_index] = RvHit;
      res.inserted_value = RvHit;
    end else begin
      n_fill++;
      role  = set_role(req.set_index);
      brrip = (role == ROLE_BRRIP) || (role == ROLE_FOLLOW && duel_cnt >= DuelHalf);
      ins   = (brrip && req.chance != '0) ? RvMax : RvNear;
      rrpv_mem[base+req.way_index] = ins;
      res.inserted_value = ins;
      if (req.victim_valid) begin
        if (role == ROLE_SRRIP && duel_cnt != DuelTop) duel_cnt++;
        else if (role == ROLE_BRRIP && duel_cnt != '0) duel_cnt--;
      end
      if (duel_cnt == DuelTop) duel_saw_top = 1'b1;
      if (duel_cnt == '0) duel_saw_floor = 1'b1;
    end
    res.duel_counter = duel_cnt;
    return res;
  endfunction

  function automatic drrip_in_t make_req(input logic cmd, input int unsigned idx,
                                         input int unsigned way, input int unsigned hit,
                                         input int unsigned vv, input int unsigned chance);
    drrip_in_t req;
    req.command      = cmd;
    req.set_index    = idx[SetInW-1:0];
    req.way_index    = way[WayInW-1:0];
    req.is_hit       = hit[0];
    req.victim_valid = vv[0];
    req.chance       = chance[ChanceW-1:0];
    return req;
  endfunction

  function automatic int unsigned rand_chance();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31);
  endfunction

  // Leader boundaries and a few followers, so rows fill up and ageing happens.
  function automatic int unsigned hot_set();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return LeaderSetsDef - 1;
      2:       return LeaderSetsDef;
      3:       return NumSetsDef / 2;
      4:       return NumSetsDef - LeaderSetsDef - 1;
      5:       return NumSetsDef - LeaderSetsDef;
      6:       return NumSetsDef - 1;
      default: return $urandom_range(0, NumSetsDef - 1);
    endcase
  endfunction

  task automatic send_request(input drrip_in_t req, output drrip_out_t res);
    if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = rrip_access(req);
    expected_q.push_back(res);
    sent++;
  endtask

  task automatic issue(input drrip_in_t req);
    drrip_out_t res;
    send_request(req, res);
  endtask

  // Miss: ask for a victim, then fill the way it names.
  task automatic miss_sequence(input int unsigned idx);
    drrip_out_t res;
    send_request(make_req(CMD_VICTIM, idx, $urandom, $urandom, $urandom, $urandom), res);
    issue(make_req(CMD_UPDATE, idx, int'(res.victim_way), 0,
                   ($urandom_range(0, 9) != 0) ? 1 : 0, rand_chance()));
  endtask

  // Touch every way of one set at near or hit value, then force a full ageing pass.
  task automatic row_sweep(input int unsigned idx);
    for (int unsigned w = 0; w < NumWaysDef; w++) begin
      issue(make_req(CMD_UPDATE, idx, w, $urandom_range(0, 1), $urandom, 0));
    end
    issue(make_req(CMD_VICTIM, idx, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic mix_step();
    int unsigned pick;
    logic [$bits(drrip_in_t)-1:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      miss_sequence(hot_set());
    end else if (pick < 72) begin
      issue(make_req(CMD_UPDATE, hot_set(), $urandom, 1, $urandom, $urandom));
    end else if (pick < 75) begin
      row_sweep(hot_set());
    end else begin
      raw = $bits(drrip_in_t)'($urandom);
      issue(drrip_in_t'(raw));
    end
  endtask

  task automatic test_directed_corners();
    idle_odds = 15;
    issue(make_req(CMD_VICTIM, 0, 0, 0, 0, 0));
    issue(make_req(CMD_VICTIM, NumSetsDef - 1, 15, 1, 1, 31));
    issue(make_req(CMD_VICTIM, NumSetsDef / 2, 0, 0, 0, 0));
    issue(make_req(CMD_UPDATE, NumSetsDef - 1, 15, 1, 1, 31));
    issue(make_req(CMD_VICTIM, NumSetsDef - 1, 0, 0, 0, 0));
    issue(make_req(CMD_UPDATE, LeaderSetsDef - 1, 15, 0, 1, 0));
    issue(make_req(CMD_UPDATE, 0, 0, 0, 0, 31));
    issue(make_req(CMD_UPDATE, NumSetsDef - LeaderSetsDef, 0, 0, 1, 31));
    issue(make_req(CMD_UPDATE, NumSetsDef - 1, 1, 0, 1, 0));
    issue(make_req(CMD_UPDATE, LeaderSetsDef, 7, 0, 1, 31));
    issue(make_req(CMD_UPDATE, NumSetsDef - LeaderSetsDef - 1, 3, 0, 1, 31));
    issue(make_req(CMD_UPDATE, 1, 8, 0, 1, 5));
    issue(make_req(CMD_UPDATE, NumSetsDef - LeaderSetsDef - 1, 4, 0, 0, 31));
    issue(make_req(CMD_UPDATE, NumSetsDef - LeaderSetsDef - 1, 5, 0, 1, 0));
    issue(make_req(CMD_VICTIM, NumSetsDef - LeaderSetsDef - 1, 0, 0, 0, 0));
    issue(make_req(CMD_UPDATE, 0, 0, 1, 1, 0));
    issue(make_req(CMD_VICTIM, 0, 0, 0, 0, 0));
    issue(make_req(CMD_UPDATE, NumSetsDef - 1, 0, 1, 1, 0));
    issue(make_req(CMD_UPDATE, 0, 1, 1, 1, 17));
    issue(make_req(CMD_VICTIM, 0, 15, 1, 1, 31));
  endtask

  task automatic test_random_mix(input int unsigned steps, input int unsigned odds);
    idle_odds = odds;
    repeat (steps) mix_step();
  endtask

  // Drive the duel counter back up from the floor through SRRIP leader fills.
  task automatic test_counter_climb(input int unsigned steps);
    for (int unsigned i = 0; i < steps; i++) begin
      idle_odds = (i < steps / 2) ? 20 : 0;
      if ($urandom_range(0, 9) != 0) begin
        issue(make_req(CMD_UPDATE, $urandom_range(0, LeaderSetsDef - 1), $urandom, 0,
                       1, rand_chance()));
      end else begin
        mix_step();
      end
    end
  endtask

  // Walk the counter down past the follower threshold and into zero.
  task automatic test_counter_descent(input int unsigned steps);
    idle_odds = 10;
    repeat (steps) begin
      if ($urandom_range(0, 99) < 93) begin
        issue(make_req(CMD_UPDATE, $urandom_range(NumSetsDef - LeaderSetsDef, NumSetsDef - 1),
                       $urandom, 0, 1, rand_chance()));
      end else begin
        mix_step();
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= (ready_hold == 1);
    end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds / 3) begin
      ready_hold  <= $urandom_range(1, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    drrip_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) $display("%0t: unexpected result %p", $time, out_data_o);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.victim_way !== want.victim_way ||
            out_data_o.inserted_value !== want.inserted_value ||
            out_data_o.duel_counter !== want.duel_counter) begin
          errors++;
          if (errors <= ReportLimit) begin
            $display("%0t: mismatch victim_way %0d/%0d inserted_value %0d/%0d duel %0d/%0d",
                     $time, out_data_o.victim_way, want.victim_way,
                     out_data_o.inserted_value, want.inserted_value,
                     out_data_o.duel_counter, want.duel_counter);
          end
        end
      end
    end
  end

  // Abort when neither channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("testbench failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : stimulus
    foreach (rrpv_mem[i]) rrpv_mem[i] = RvMax;
    duel_cnt = DuelHalf;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_random_mix(100, 30);
    test_counter_descent(620);
    test_counter_climb(500);
    test_random_mix(50, 0);

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d transactions: %0d victim, %0d hit, %0d fill",
             sent, n_victim, n_hit, n_fill);
    $display("Ageing 0/1/2/3: %0d/%0d/%0d/%0d; duel top %0d, floor %0d; mismatches: %0d",
             ageing_seen[0], ageing_seen[1], ageing_seen[2], ageing_seen[3],
             duel_saw_top, duel_saw_floor, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
